>>> design/shp3_pkg.sv
// Shared types and constants of the 3x3 sharpen filter.
`default_nettype none

package shp3_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int ROW_W       = 12;
    localparam int POS_W       = 12;
    localparam int WIDTH_W     = 11;
    localparam int CHAN_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCOUNT_W    = 3;
    localparam int ACC_W       = 13;
    localparam int KERNEL_GAIN = 5;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd512;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 12'd512;
    localparam logic [CHAN_W-1:0]  CHAN_RESET   = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [WIDTH_W-1:0] image_width;
        logic [ROW_W-1:0]   image_height;
        logic [CHAN_W-1:0]  channel_count;
    } t_cfg;

    // One queued item: the delayed-row result plus what the last row needs.
    typedef struct packed {
        logic [SAMPLE_W-1:0] pixel_value;
        logic [SAMPLE_W-1:0] sample;
        logic [ROW_W-1:0]    row;
        logic [POS_W-1:0]    pos;
        logic                last_row;
        logic                frame_end;
    } t_entry;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } t_back_state;

endpackage

`default_nettype wire

>>> design/shp3_front.sv
// Front end: input handshake, raster counters, line buffers and the kernel.
`default_nettype none

module shp3_front #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_restart,
    input  shp3_pkg::t_cfg                  i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [shp3_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [shp3_pkg::QCOUNT_W-1:0]   i_q_count,
    output logic                            o_push,
    output shp3_pkg::t_entry                o_entry
);
    import shp3_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int LW = $clog2(LINE_DEPTH + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [WW-1:0]       eff_w;
    logic [CHAN_W-1:0]   eff_c;
    logic [ROW_W-1:0]    eff_h;
    logic [LW-1:0]       len;
    logic [LW-1:0]       len_hi;
    logic [LW-1:0]       pos_inc;
    logic [AW+1:0]       right_sum;
    logic [AW-1:0]       addr_right;
    logic [QCOUNT_W:0]   slots_used;
    logic                accept;
    logic                last_row;
    logic                interior;
    logic [HW-1:0]       left_idx;

    logic [AW-1:0]       r_pos;
    logic [ROW_W-1:0]    r_row;

    logic                r_s1_valid;
    logic                r_s1_emit;
    logic                r_s1_interior;
    logic                r_s1_last_row;
    logic                r_s1_frame_end;
    logic [ROW_W-1:0]    r_s1_row;
    logic [AW-1:0]       r_s1_addr;
    logic [SAMPLE_W-1:0] r_s1_sample;

    logic [SAMPLE_W-1:0] r_mid_mem [LINE_DEPTH];
    logic [SAMPLE_W-1:0] r_up_mem  [LINE_DEPTH];
    logic [SAMPLE_W-1:0] r_centre;
    logic [SAMPLE_W-1:0] r_right;
    logic [SAMPLE_W-1:0] r_up;
    logic [SAMPLE_W-1:0] r_hist [MAX_CHANNELS];

    logic [SAMPLE_W-1:0] left;
    logic [ACC_W-1:0]    acc;
    logic [SAMPLE_W-1:0] clamped;

    // Effective geometry from the raw register values.
    always_comb begin
        if (i_cfg.image_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(i_cfg.image_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(i_cfg.image_width);
        end
        if (i_cfg.channel_count == '0) begin
            eff_c = CHAN_W'(1);
        end else if (32'(i_cfg.channel_count) > MAX_CHANNELS) begin
            eff_c = CHAN_W'(MAX_CHANNELS);
        end else begin
            eff_c = i_cfg.channel_count;
        end
        eff_h  = (i_cfg.image_height < 12'd2) ? 12'd2 : i_cfg.image_height;
        len    = LW'(eff_w) * LW'(eff_c);
        len_hi = len - LW'(eff_c);
    end

    assign slots_used = (QCOUNT_W+1)'(i_q_count) + (QCOUNT_W+1)'(r_s1_valid);
    assign o_in_ready = slots_used < (QCOUNT_W+1)'(QUEUE_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    assign pos_inc    = LW'(r_pos) + LW'(1);
    assign last_row   = (r_row == eff_h - 12'd1);
    assign interior   = (r_row >= 12'd2) && (LW'(r_pos) >= LW'(eff_c))
                        && (LW'(r_pos) < len_hi);

    // The right neighbour address may run past the buffer near the row end;
    // its data is then never used.
    assign right_sum  = (AW+2)'(r_pos) + (AW+2)'(eff_c);
    assign addr_right = (right_sum < (AW+2)'(LINE_DEPTH)) ? right_sum[AW-1:0] : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pos <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (pos_inc >= len) begin
                r_pos <= '0;
                r_row <= last_row ? '0 : r_row + 12'd1;
            end else begin
                r_pos <= r_pos + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit      <= (r_row != '0);
            r_s1_interior  <= interior;
            r_s1_last_row  <= last_row;
            r_s1_frame_end <= last_row && (pos_inc == len);
            r_s1_row       <= r_row;
            r_s1_addr      <= r_pos;
            r_s1_sample    <= i_sample;
        end
    end

    // Middle line: the read of the old centre happens before it is replaced.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_centre         <= r_mid_mem[r_pos];
            r_right          <= r_mid_mem[addr_right];
            r_mid_mem[r_pos] <= i_sample;
        end
    end

    // Upper line: the centre moves up once it has been read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up <= r_up_mem[r_pos];
        end
        if (r_s1_valid && r_s1_emit) begin
            r_up_mem[r_s1_addr] <= r_centre;
        end
    end

    // The last few centres; the left neighbour is one pixel back.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_hist[0] <= r_centre;
            for (int i = 1; i < MAX_CHANNELS; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    assign left_idx = HW'(eff_c - CHAN_W'(1));
    assign left     = r_hist[left_idx];

    always_comb begin
        acc = ACC_W'(KERNEL_GAIN) * ACC_W'(r_centre) - ACC_W'(left) - ACC_W'(r_right)
              - ACC_W'(r_up) - ACC_W'(r_s1_sample);
        if (acc[ACC_W-1]) begin
            clamped = '0;
        end else if (acc[ACC_W-2:SAMPLE_W] != '0) begin
            clamped = '1;
        end else begin
            clamped = acc[SAMPLE_W-1:0];
        end
    end

    assign o_push = r_s1_valid && r_s1_emit;

    always_comb begin
        o_entry.pixel_value = r_s1_interior ? clamped : r_centre;
        o_entry.sample      = r_s1_sample;
        o_entry.row         = r_s1_row;
        o_entry.pos         = POS_W'(r_s1_addr);
        o_entry.last_row    = r_s1_last_row;
        o_entry.frame_end   = r_s1_frame_end;
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_q_count < QCOUNT_W'(QUEUE_DEPTH)))
        else $error("front pushed into a full queue");

    a_row0_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_row == '0 && !i_restart) |=> !o_push)
        else $error("first-row word produced a result");

endmodule

`default_nettype wire

>>> design/shp3_queue.sv
// Short queue of finished items between the front end and the output side.
`default_nettype none

module shp3_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  shp3_pkg::t_entry               i_entry,
    input  logic                           i_pop,
    output shp3_pkg::t_entry               o_head,
    output logic                           o_empty,
    output logic [shp3_pkg::QCOUNT_W-1:0]  o_count
);
    import shp3_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCOUNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCOUNT_W'(i_push) - QCOUNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

>>> design/shp3_back.sv
// Output side: expands each queued item into one or two output words.
`default_nettype none

module shp3_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  shp3_pkg::t_entry              i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [shp3_pkg::SAMPLE_W-1:0] o_pixel_value,
    output logic [shp3_pkg::ROW_W-1:0]    o_out_row,
    output logic [shp3_pkg::POS_W-1:0]    o_out_pos,
    output logic                          o_run_last,
    output logic                          o_frame_done
);
    import shp3_pkg::*;

    t_back_state         r_state;
    t_back_state         n_state;
    logic                can_load;
    logic                load;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_pixel_value;
    logic [ROW_W-1:0]    r_out_row;
    logic [POS_W-1:0]    r_out_pos;
    logic                r_run_last;
    logic                r_frame_done;

    logic [SAMPLE_W-1:0] n_pixel_value;
    logic [ROW_W-1:0]    n_out_row;
    logic                n_run_last;
    logic                n_frame_done;

    assign can_load = !r_out_valid || i_out_ready;
    assign load     = can_load && !i_empty;

    always_comb begin
        n_state = r_state;
        if (load) begin
            case (r_state)
                BK_FIRST:  n_state = i_head.last_row ? BK_SECOND : BK_FIRST;
                BK_SECOND: n_state = BK_FIRST;
                default:   n_state = BK_FIRST;
            endcase
        end
    end

    always_comb begin
        case (r_state)
            BK_FIRST: begin
                n_pixel_value = i_head.pixel_value;
                n_out_row     = i_head.row - ROW_W'(1);
                n_run_last    = !i_head.last_row;
                n_frame_done  = 1'b0;
                o_pop         = load && !i_head.last_row;
            end
            BK_SECOND: begin
                n_pixel_value = i_head.sample;
                n_out_row     = i_head.row;
                n_run_last    = 1'b1;
                n_frame_done  = i_head.frame_end;
                o_pop         = load;
            end
            default: begin
                n_pixel_value = i_head.pixel_value;
                n_out_row     = i_head.row;
                n_run_last    = 1'b1;
                n_frame_done  = 1'b0;
                o_pop         = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (can_load) begin
                r_out_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel_value <= n_pixel_value;
            r_out_row     <= n_out_row;
            r_out_pos     <= i_head.pos;
            r_run_last    <= n_run_last;
            r_frame_done  <= n_frame_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_pixel_value;
    assign o_out_row     = r_out_row;
    assign o_out_pos     = r_out_pos;
    assign o_run_last    = r_run_last;
    assign o_frame_done  = r_frame_done;

    a_second_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SECOND) |-> (!i_empty && i_head.last_row))
        else $error("second word pending without a last-row item");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_frame_done) |-> r_run_last)
        else $error("frame end not on the final word of its item");

endmodule

`default_nettype wire

>>> design/sharpen_3x3_filter.sv
// Top level of the streaming 3x3 sharpen filter with its configuration registers.
`default_nettype none

// Streaming 3x3 Laplacian sharpen for interleaved 8-bit components in raster
// order. Each accepted word of row r releases the result for row r-1 at the
// same position: 5*centre minus the left, right, upper and lower neighbours
// of the same channel, clamped to 0..255; the first and last rows and the
// first and last pixel of every row are copied unchanged. Words of row 0
// produce nothing, and words of the last row produce two results, the
// delayed row first and then their own copy. While the output is ready, the
// block takes one word per clock and gives one result word per clock, so it
// keeps up with a full-rate stream except in the last row, where the single
// output port gives two words per input word and the input side backs up
// through the four-entry queue. A result goes from the stage-one registers
// through the queue into the output register. The front
// end holds the counters, the two line buffers (MAX_WIDTH*MAX_CHANNELS
// entries each, one write and up to two reads per clock) and the kernel; a
// short queue decouples it from the output side, which expands each item
// into its words. The line buffers are not cleared; they only ever supply
// rows written earlier in the same frame. Any configuration write restarts
// the frame at row 0 and is taken at once (the configuration channel is
// always ready); a write to an index past the register list is ignored.
module sharpen_3x3_filter #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [shp3_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [shp3_pkg::SAMPLE_W-1:0]   o_pixel_value,
    output logic [shp3_pkg::ROW_W-1:0]      o_out_row,
    output logic [shp3_pkg::POS_W-1:0]      o_out_pos,
    output logic                            o_run_last,
    output logic                            o_frame_done,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [shp3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [shp3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import shp3_pkg::*;

    t_cfg                r_cfg;
    logic                cfg_hit;
    logic                push;
    logic                pop;
    logic                q_empty;
    logic [QCOUNT_W-1:0] q_count;
    t_entry              push_entry;
    t_entry              q_head;

    // The configuration channel never stalls.
    assign o_cfg_ready = 1'b1;

    // A write to any listed register also restarts the frame.
    assign cfg_hit = i_cfg_valid && (i_cfg_index == CFG_IMAGE_WIDTH
                     || i_cfg_index == CFG_IMAGE_HEIGHT
                     || i_cfg_index == CFG_CHANNEL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width   <= WIDTH_RESET;
            r_cfg.image_height  <= HEIGHT_RESET;
            r_cfg.channel_count <= CHAN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_data[ROW_W-1:0];
                CFG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Counters, line buffers and the kernel itself.
    shp3_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (cfg_hit),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sample   (i_sample),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // Finished items wait here, so the input side keeps moving while the
    // output side is stalled, until the queue is full.
    shp3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // One or two result words per item into the output register.
    shp3_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_value (o_pixel_value),
        .o_out_row     (o_out_row),
        .o_out_pos     (o_out_pos),
        .o_run_last    (o_run_last),
        .o_frame_done  (o_frame_done)
    );

endmodule

`default_nettype wire
